// ----- sv/stt_pkg.sv -----
// Package for the software timer table: payload structs, command and result codes.
// Used by all stt_* modules and software_timer_table_core.
package stt_pkg;
    localparam int NumTimers = 16;
    localparam int IdxW      = $clog2(NumTimers);
    localparam int MaxOut    = 16;
    localparam int CntW      = $clog2(MaxOut + 1);

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_START    = 2'd1;
    localparam logic [1:0] CMD_STOP     = 2'd2;
    localparam logic [1:0] CMD_STOP_ALL = 2'd3;

    localparam logic [1:0] KIND_EXPIRED = 2'd0;
    localparam logic [1:0] KIND_STARTED = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         owner_id;
        logic [31:0]        timer_id;
        logic signed [31:0] user_code;
        logic [30:0]        timeout_ms;
        logic               periodic;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         owner_out;
        logic [31:0]        timer_id_out;
        logic signed [31:0] user_code_out;
        logic               last;
    } t_out;
endpackage

// ----- sv/stt_front.sv -----
// Front end: accepts items, fixes timeout zero, holds them in a two-entry queue.
// Depends on stt_pkg.
module stt_front import stt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_q_valid,
    input  logic i_q_take,
    output t_in  o_q_data
);
    t_in        r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       w_push;
    t_in        w_item;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_q[r_rd];

    always_comb begin
        w_item = i_data;
        if (i_data.cmd == CMD_START && i_data.timeout_ms == '0) begin
            w_item.timeout_ms = 31'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_take};
            if (i_q_take) begin
                r_rd <= ~r_rd;
            end
        end
        if (w_push) begin
            r_q[r_rd ^ (r_cnt != 2'd0) ^ (r_cnt == 2'd2)] <= w_item;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_q_take |-> o_q_valid)
        else $error("queue pop while empty");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
endmodule

// ----- sv/stt_back.sv -----
// Back end: timer table, time counter, scan sequencer and output register.
// Depends on stt_pkg.
module stt_back import stt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    output logic o_q_take,
    input  t_in  i_q_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [NumTimers-1:0] r_valid;
    logic [7:0]           r_own   [NumTimers];
    logic [31:0]          r_id    [NumTimers];
    logic [31:0]          r_code  [NumTimers];
    logic [30:0]          r_per   [NumTimers];
    logic                 r_pflag [NumTimers];
    logic [31:0]          r_dl    [NumTimers];
    logic [15:0]          r_ord   [NumTimers];

    logic [31:0]   r_now;
    logic [15:0]   r_seq;
    logic [1:0]    r_st;
    logic [IdxW:0] r_ix;
    logic          r_found;
    logic [IdxW-1:0] r_best;
    logic [31:0]   r_bkey;
    logic [15:0]   r_bage;
    logic [CntW-1:0] r_n;
    logic          r_ov;
    t_out          r_od;
    logic [7:0]    r_p_own;
    logic [31:0]   r_p_id;
    logic [31:0]   r_p_code;

    logic          w_out_free;
    logic [IdxW-1:0] w_i, w_free;
    logic          w_any_free;
    logic [31:0]   w_key;
    logic [15:0]   w_age;
    logic          w_better;
    logic          w_scan_end;
    logic          w_more;
    logic          w_ld_start;
    logic          w_ld_exp;

    assign w_out_free = !r_ov || !i_stall;
    assign o_valid = r_ov;
    assign o_data  = r_od;
    assign o_q_take = i_q_valid && r_st == ST_IDLE && w_out_free;
    assign w_i   = r_ix[IdxW-1:0];
    assign w_key = r_dl[w_i] - r_now + 32'h8000_0000;
    assign w_age = r_seq - r_ord[w_i];
    assign w_better = r_valid[w_i] && w_key <= 32'h8000_0000 &&
        (!r_found || w_key < r_bkey || (w_key == r_bkey && w_age > r_bage));
    assign w_scan_end = (r_st == ST_SCAN) && (r_ix == (IdxW+1)'(NumTimers));
    assign w_more     = r_found && r_n != CntW'(MaxOut);
    assign w_ld_start = o_q_take && i_q_data.cmd == CMD_START;
    assign w_ld_exp   = w_scan_end && r_n != '0 && w_out_free;

    always_comb begin
        w_free = '0;
        w_any_free = 1'b0;
        for (int k = NumTimers - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                w_free = k[IdxW-1:0];
                w_any_free = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_now   <= '0;
            r_seq   <= '0;
            r_st    <= ST_IDLE;
            r_ov    <= 1'b0;
            r_found <= 1'b0;
            r_ix    <= '0;
            r_n     <= '0;
        end else begin
            r_ov <= w_ld_start || w_ld_exp || (r_ov && i_stall);
            unique case (r_st)
                ST_IDLE: begin
                    if (o_q_take) begin
                        unique case (i_q_data.cmd)
                            CMD_TICK: begin
                                r_now   <= r_now + 32'd1;
                                r_st    <= ST_SCAN;
                                r_ix    <= '0;
                                r_found <= 1'b0;
                                r_n     <= '0;
                            end
                            CMD_START: begin
                                r_od.owner_out     <= i_q_data.owner_id;
                                r_od.timer_id_out  <= i_q_data.timer_id;
                                r_od.user_code_out <= i_q_data.user_code;
                                r_od.last          <= 1'b1;
                                if (w_any_free) begin
                                    r_od.kind <= KIND_STARTED;
                                    r_valid[w_free] <= 1'b1;
                                    r_own[w_free]   <= i_q_data.owner_id;
                                    r_id[w_free]    <= i_q_data.timer_id;
                                    r_code[w_free]  <= i_q_data.user_code;
                                    r_per[w_free]   <= i_q_data.timeout_ms;
                                    r_pflag[w_free] <= i_q_data.periodic;
                                    r_dl[w_free]    <= r_now +
                                                       {1'b0, i_q_data.timeout_ms};
                                    r_ord[w_free]   <= r_seq;
                                    r_seq           <= r_seq + 16'd1;
                                end else begin
                                    r_od.kind <= KIND_FULL;
                                end
                            end
                            default: begin
                                for (int k = 0; k < NumTimers; k++) begin
                                    if (r_valid[k] && r_own[k] == i_q_data.owner_id &&
                                        (i_q_data.cmd == CMD_STOP_ALL ||
                                         (r_id[k] == i_q_data.timer_id &&
                                          (i_q_data.user_code == '0 ||
                                           r_code[k] == i_q_data.user_code)))) begin
                                        r_valid[k] <= 1'b0;
                                    end
                                end
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (w_scan_end) begin
                        // parked result goes out once the rescan tells if it is the last
                        if (r_n == '0 || w_out_free) begin
                            if (r_n != '0) begin
                                r_od.kind          <= KIND_EXPIRED;
                                r_od.owner_out     <= r_p_own;
                                r_od.timer_id_out  <= r_p_id;
                                r_od.user_code_out <= r_p_code;
                                r_od.last          <= !w_more;
                            end
                            r_st <= w_more ? ST_EMIT : ST_IDLE;
                        end
                    end else begin
                        if (w_better) begin
                            r_found <= 1'b1;
                            r_best  <= w_i;
                            r_bkey  <= w_key;
                            r_bage  <= w_age;
                        end
                        r_ix <= r_ix + 1'b1;
                    end
                end
                ST_EMIT: begin
                    r_p_own  <= r_own[r_best];
                    r_p_id   <= r_id[r_best];
                    r_p_code <= r_code[r_best];
                    r_n <= r_n + 1'b1;
                    if (r_pflag[r_best]) begin
                        r_dl[r_best]  <= r_dl[r_best] + {1'b0, r_per[r_best]};
                        r_ord[r_best] <= r_seq;
                        r_seq         <= r_seq + 16'd1;
                    end else begin
                        r_valid[r_best] <= 1'b0;
                    end
                    r_st    <= ST_SCAN;
                    r_ix    <= '0;
                    r_found <= 1'b0;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_SCAN) |-> !o_q_take)
        else $error("item taken during scan");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_EMIT) |-> r_found)
        else $error("emit without due entry");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");
endmodule

// ----- sv/software_timer_table_core.sv -----
// Top level of the software timer table: front queue feeding the table engine.
// Depends on stt_pkg, stt_front, stt_back.
//  channel | valid   | stall   | payload
//  in      | i_valid | o_stall | i_data (t_in)
//  out     | o_valid | i_stall | o_data (t_out)
// Start and stop pass through the queue and are handled by the idle engine; a tick
// is taken and scans every entry, and each expiry adds an emit step plus a rescan.
// Each expiry is parked one scan until its last flag is known; a scan end with a
// parked result waits while the output register is stalled.
// Reset clears the table valid bits, time and sequence counters synchronously.
// Input is stalled only when the two-entry queue is full.
module software_timer_table_core import stt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    logic w_qv, w_take;
    t_in  w_qd;

    stt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_q_valid(w_qv), .i_q_take(w_take), .o_q_data(w_qd)
    );

    stt_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .o_q_take(w_take), .i_q_data(w_qd),
        .o_valid, .i_stall, .o_data
    );
endmodule
